@@ src/odq_pkg.sv @@
// ---------------------------------------------------------------------------
// odq_pkg - shared types for the ordered deque
// Action and status codes, beat payloads and controller/datapath links.
// ---------------------------------------------------------------------------
`default_nettype none

package odq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ValW      = 32;
  localparam int CountW    = 5;

  typedef enum logic [1:0] {
    ACT_FRONT  = 2'd0,
    ACT_REAR   = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    action_e                  action;
    logic signed [ValW-1:0]   value;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic [CountW-1:0]        count;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ src/odq_ctrl.sv @@
// ---------------------------------------------------------------------------
// odq_ctrl - sequencing controller
// Accepts one beat at a time, steps the delete sweep, owns output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module odq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire odq_pkg::dp_stat_t stat_i,
  output odq_pkg::ctrl_cmd_t    cmd_o
);
  import odq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = stat_i.need_scan ? S_SCAN : S_RESULT;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    accept     = in_valid_i && in_ready_o;
    out_load   = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    cmd_o.accept   = accept;
    cmd_o.scan     = (state_q == S_SCAN);
    cmd_o.out_load = out_load;
    out_valid_o    = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ src/odq_dpath.sv @@
// ---------------------------------------------------------------------------
// odq_dpath - entry cells, fill count and result registers
// Cells shift as a chain; delete rotates the list through the head cell.
// ---------------------------------------------------------------------------
`default_nettype none

module odq_dpath #(
  parameter int DEPTH = odq_pkg::DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire odq_pkg::in_t      in_i,
  input  wire odq_pkg::ctrl_cmd_t cmd_i,
  output odq_pkg::dp_stat_t      stat_o,
  output odq_pkg::out_t          out_o
);
  import odq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [ValW-1:0] cell_q [DEPTH];
  logic [ValW-1:0] cell_d [DEPTH];
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   step_q, step_d;
  logic            found_q, found_d;
  logic [ValW-1:0] key_q, key_d;
  out_t            res_q, res_d;
  out_t            out_q;
  logic            full;
  logic            hit;
  logic            res_load;
  logic [CW-1:0]   tail;

  assign full = (count_q == CW'(DEPTH));
  assign hit  = (cell_q[0] == key_q) && !found_q;
  assign tail = count_q - CW'(1);

  assign stat_o.need_scan = (in_i.action == ACT_DELETE) && (count_q != '0);
  assign stat_o.scan_last = (step_q == CW'(1));

  always_comb begin
    cell_d   = cell_q;
    count_d  = count_q;
    step_d   = step_q;
    found_d  = found_q;
    key_d    = key_q;
    res_d    = res_q;
    res_load = 1'b0;
    if (cmd_i.accept) begin
      res_load = 1'b1;
      res_d.status = ST_DONE;
      unique case (in_i.action)
        ACT_FRONT: begin
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            for (int i = 1; i < DEPTH; i++) begin
              cell_d[i] = cell_q[i-1];
            end
            cell_d[0] = in_i.value;
            count_d   = count_q + CW'(1);
          end
        end
        ACT_REAR: begin
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (CW'(i) == count_q) begin
                cell_d[i] = in_i.value;
              end
            end
            count_d = count_q + CW'(1);
          end
        end
        ACT_DELETE: begin
          key_d   = in_i.value;
          step_d  = count_q;
          found_d = 1'b0;
          if (count_q == '0) begin
            res_d.status = ST_NOT_FOUND;
          end else begin
            res_load = 1'b0;
          end
        end
        ACT_CLEAR: begin
          count_d = '0;
        end
        default: ;
      endcase
      res_d.count = CountW'(count_d);
    end else if (cmd_i.scan) begin
      // one rotation step: head leaves, and returns at the tail unless it is
      // the first match
      for (int i = 0; i < DEPTH - 1; i++) begin
        cell_d[i] = cell_q[i+1];
      end
      if (!hit) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) == tail) begin
            cell_d[i] = cell_q[0];
          end
        end
      end
      count_d = hit ? tail : count_q;
      found_d = found_q || hit;
      step_d  = step_q - CW'(1);
      if (stat_o.scan_last) begin
        res_load     = 1'b1;
        res_d.status = (found_q || hit) ? ST_DONE : ST_NOT_FOUND;
        res_d.count  = CountW'(count_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_q[i] <= cell_d[i];
    end
    key_q <= key_d;
    step_q <= step_d;
    found_q <= found_d;
    if (res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

@@ src/ordered_deque_with_value_delete.sv @@
// ---------------------------------------------------------------------------
// ordered_deque_with_value_delete - ordered list with front/rear insert,
// delete-first-match and clear
// Top level: joins the sequencing controller to the entry datapath.
// ---------------------------------------------------------------------------
// Holds up to DEPTH 32-bit values in order, entry 0 at the front. Each input
// beat carries one action and returns one output beat with a status (done,
// full, not found) and the entry count after the action; the count field is
// the low five bits of that count. One beat is worked on at a time. Insert
// front, insert rear and clear, and a delete on an empty list, load the
// result register on acceptance; the result then moves on to the output
// register once that is free, and only then is the next beat taken. A delete
// on a non-empty list first rotates the list through the head cell once, one
// entry per cycle, comparing the head against the key and dropping the first
// match, so the cost follows the length of the list. The output register is
// separate from the result register, so a new beat is taken while the
// previous result still waits downstream; a stalled output only holds the
// engine once a further result is ready. Entry storage has no reset; only
// the fill count is cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module ordered_deque_with_value_delete #(
  parameter int DEPTH = odq_pkg::DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // input beats
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire odq_pkg::in_t  in_i,
  // output beats
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output odq_pkg::out_t      out_o
);
  import odq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // controller: beat acceptance, sweep sequencing, output valid
  odq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: cell chain, count, key, result and output registers
  odq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

@@ src/odq_checker.sv @@
// ---------------------------------------------------------------------------
// odq_checker - port-level checks for the ordered deque
// Watches handshakes and result beats; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module odq_checker #(
  parameter int DEPTH = odq_pkg::DEPTH_DEF
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire odq_pkg::in_t  in_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire odq_pkg::out_t out_o
);
  import odq_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output beat dropped or changed while stalled");

  // one beat in flight: busy on the cycle after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous beat still in work");

  // a new result appears only from the busy phase
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a beat in work");

  // full rejection reports a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == ST_FULL) |-> out_o.count == CountW'(DEPTH))
    else $error("full status with count not at depth");

endmodule

bind ordered_deque_with_value_delete odq_checker #(.DEPTH(DEPTH)) u_odq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

`default_nettype wire

@@ tb/ordered_deque_with_value_delete_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ordered_deque_with_value_delete_tb - self-checking bench for the deque
// A queue-fed driver offers action beats and a monitor checks every result
// beat against a shadow copy of the list kept in a SystemVerilog queue.
// ---------------------------------------------------------------------------
// Flow: a directed opening (empty list, extreme values, filling to full,
// rejections, deletes at front, middle and rear, duplicates, clear), then three
// random phases of about 200 beats each. The idle pattern changes per phase:
// sender idles 30 % and receiver 54 %, then the other way round, then no idling
// at all. In the last phase the receiver holds off for a long stretch, so the
// block fills up and stalls its input. Between phases the sender pauses until
// every outstanding result has been checked.
// ---------------------------------------------------------------------------

module ordered_deque_with_value_delete_tb;
  import odq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int PHASE_BEATS = 200;
  localparam int HOLD_CYCLES = 200;       // long output hold-off
  localparam int SETTLE      = 60;        // covers a delete sweep over a full list
  localparam int CYCLE_LIMIT = 400000;

  // clock, reset and DUT ports; everything known from time zero
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_beat     = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  // stimulus and checking state
  in_t           pending[$];              // beats waiting for the driver
  out_t          awaited[$];              // predicted results, oldest first
  logic [31:0]   held[$];                 // shadow of the list, front first
  logic [31:0]   val_pool[8];             // small pool so deletes often hit
  logic          in_taken      = 1'b0;
  int            send_idle_pct = 0;
  int            rcv_stall_pct = 0;
  logic          hold_req      = 1'b0;    // toggled to request a hold-off
  logic          hold_ack      = 1'b0;
  int            hold_left     = 0;
  int            cycle_cnt     = 0;
  int            n_errors      = 0;
  int            n_checked     = 0;
  int            n_full        = 0;
  int            n_miss        = 0;
  int            n_del_hit     = 0;
  int            n_clear       = 0;
  int            peak_count    = 0;
  int            n_ready_low   = 0;       // cycles with result beat stalled

  always #10 clk_i = ~clk_i;

  ordered_deque_with_value_delete #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_beat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // -------------------------------------------------------------------------
  // Shadow list: apply one action and return the result beat it should give.
  // Delete takes the first match nearest the front; later entries close up.
  // -------------------------------------------------------------------------
  function automatic out_t apply_action(in_t beat);
    out_t res;
    int   hit;
    res.status = ST_DONE;
    hit        = -1;
    case (beat.action)
      ACT_FRONT, ACT_REAR: begin
        if (held.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else if (beat.action == ACT_FRONT) begin
          held.push_front(beat.value);
        end else begin
          held.push_back(beat.value);
        end
      end
      ACT_DELETE: begin
        foreach (held[i]) begin
          if (hit < 0 && held[i] == beat.value) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          held.delete(hit);
        end
      end
      default: begin
        held = {};
      end
    endcase
    res.count = CountW'(held.size());
    return res;
  endfunction

  task automatic report_mismatch(string what, int want_v, int got_v);
    $display("%0t  mismatch: %s, expected %0d, got %0d", $time, what, want_v, got_v);
    n_errors++;
  endtask

  // -------------------------------------------------------------------------
  // Driver: payload and valid change on the falling edge only. A new beat is
  // offered once the previous one has gone (or none was offered), so valid
  // and payload hold steady until accepted.
  // -------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_beat    <= pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here when asked.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: on each rising edge check any result beat against the oldest
  // prediction, then predict for any action beat taken on that same edge.
  // A result passes through the result and output registers after acceptance, so the two never concern the same beat.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor_p
    out_t want;
    out_t got;
    cycle_cnt <= cycle_cnt + 1;
    in_taken  <= rst_ni && in_valid_i && in_ready_o;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t  timed out with %0d results outstanding", $time, awaited.size());
      $display("FAIL ordered_deque_with_value_delete");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && !out_ready_i) n_ready_low++;
      if (out_valid_o && out_ready_i) begin
        if (awaited.size() == 0) begin
          report_mismatch("result beat with nothing outstanding, count", -1, out_o.count);
        end else begin
          want = awaited.pop_front();
          if (out_o.status !== want.status)
            report_mismatch("status", want.status, out_o.status);
          if (out_o.count !== want.count)
            report_mismatch("count", want.count, out_o.count);
          n_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        got = apply_action(in_beat);
        awaited.push_back(got);
        if (got.status == ST_FULL) n_full++;
        if (got.status == ST_NOT_FOUND) n_miss++;
        if (in_beat.action == ACT_DELETE && got.status == ST_DONE) n_del_hit++;
        if (in_beat.action == ACT_CLEAR) n_clear++;
        if (held.size() > peak_count) peak_count = held.size();
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic queue_beat(action_e act, logic [31:0] val);
    in_t beat;
    beat.action = act;
    beat.value  = val;
    pending.push_back(beat);
  endtask

  // pool values make deletes find their target; raw values cover every bit
  function automatic logic [31:0] pick_value(int pool_pct);
    if ($urandom_range(99) < pool_pct) return val_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // sender stops until the block has returned every outstanding result
  task automatic wait_drained();
    while (pending.size() != 0 || in_valid_i || awaited.size() != 0) @(posedge clk_i);
  endtask

  // runs of random length, each with its own insert bias, so the list swings
  // between empty and full; clears are rare so deep states are reached
  task automatic random_run(int n_beats);
    int left;
    int run;
    int ins_pct;
    int pick;
    left = n_beats;
    while (left > 0) begin
      run     = $urandom_range(40, 10);
      ins_pct = $urandom_range(85, 30);
      for (int k = 0; k < run && left > 0; k++) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          queue_beat(ACT_CLEAR, $urandom);
        end else if (pick < ins_pct) begin
          queue_beat($urandom_range(1) ? ACT_FRONT : ACT_REAR, pick_value(60));
        end else begin
          queue_beat(ACT_DELETE, pick_value(85));
        end
        left--;
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence of the run
  // -------------------------------------------------------------------------
  initial begin
    val_pool[0] = 32'h0000_0000;
    val_pool[1] = 32'hFFFF_FFFF;
    val_pool[2] = 32'h8000_0000;
    val_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) val_pool[i] = $urandom;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed opening, with the first idle pattern
    send_idle_pct = 30;
    rcv_stall_pct = 54;
    queue_beat(ACT_DELETE, 32'h0000_0000);    // delete from empty list
    queue_beat(ACT_CLEAR,  32'hFFFF_FFFF);    // clear when empty, value ignored
    queue_beat(ACT_FRONT,  32'h7FFF_FFFF);
    queue_beat(ACT_REAR,   32'h8000_0000);
    queue_beat(ACT_FRONT,  32'h0000_0000);
    queue_beat(ACT_REAR,   32'hFFFF_FFFF);    // 0, max, min, -1
    queue_beat(ACT_DELETE, 32'h0000_0001);    // absent value
    queue_beat(ACT_DELETE, 32'h8000_0000);    // middle delete
    queue_beat(ACT_DELETE, 32'hFFFF_FFFF);    // rear delete
    queue_beat(ACT_DELETE, 32'h0000_0000);    // front delete
    for (int i = 0; i < DEPTH - 1; i++)
      queue_beat(ACT_REAR, (i % 2 == 0) ? 32'h5555_5555 : 32'hAAAA_AAAA);
    queue_beat(ACT_FRONT,  32'h1234_5678);    // full: rejected
    queue_beat(ACT_REAR,   32'h1234_5678);    // full: rejected
    queue_beat(ACT_DELETE, 32'hAAAA_AAAA);    // first of many duplicates
    queue_beat(ACT_CLEAR,  32'h0000_0000);
    wait_drained();

    // phase one: sender idles 30 %, receiver stalls 54 %
    random_run(PHASE_BEATS);
    wait_drained();

    // phase two: swapped
    send_idle_pct = 54;
    rcv_stall_pct = 30;
    random_run(PHASE_BEATS);
    wait_drained();

    // phase three: no idling, but a long output hold-off at the start; the
    // sender keeps offering so the block backs up and drops in_ready
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    for (int i = 0; i < 24; i++) queue_beat(ACT_REAR, pick_value(60));
    random_run(PHASE_BEATS - 24);
    hold_req = ~hold_req;
    wait_drained();

    repeat (SETTLE) @(posedge clk_i);
    if (awaited.size() != 0)
      report_mismatch("results never returned", 0, awaited.size());

    $display("Checked %0d result beats: %0d deletes found, %0d misses, %0d full rejections,",
             n_checked, n_del_hit, n_miss, n_full);
    $display("%0d clears, peak fill %0d of %0d, %0d stalled output cycles, %0d mismatches",
             n_clear, peak_count, DEPTH, n_ready_low, n_errors);
    if (n_errors == 0) begin
      $display("PASS ordered_deque_with_value_delete");
    end else begin
      $display("FAIL ordered_deque_with_value_delete");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/odq_pkg.sv
src/odq_ctrl.sv
src/odq_dpath.sv
src/ordered_deque_with_value_delete.sv
src/odq_checker.sv
tb/ordered_deque_with_value_delete_tb.sv
